### rtl/core/kiss_pkg.sv
`timescale 1ns / 1ps
// kiss_pkg: shared types of the key/index stable sorter.
// No dependencies.
package kiss_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned IdxW = 6;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [IdxW-1:0]        idx_t;

  typedef struct packed {
    logic valid;
    key_t key;
    idx_t idx;
  } cell_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    StLoad  = 2'b01,
    StDrain = 2'b10
  } state_e;

endpackage

### rtl/core/kiss_if.sv
`timescale 1ns / 1ps
// kiss_in_if / kiss_out_if: valid/ready channels of the sorter.
// Depends on kiss_pkg.
interface kiss_in_if;
  import kiss_pkg::*;
  logic valid;
  logic ready;
  key_t key;
  logic last_item;

  modport source (output valid, output key, output last_item, input ready);
  modport sink (input valid, input key, input last_item, output ready);
endinterface

interface kiss_out_if;
  import kiss_pkg::*;
  logic valid;
  logic ready;
  key_t sorted_key;
  idx_t origin_index;
  logic final_pair;

  modport source (output valid, output sorted_key, output origin_index, output final_pair,
                  input ready);
  modport sink (input valid, input sorted_key, input origin_index, input final_pair,
                output ready);
endinterface

### rtl/core/kiss_cell.sv
`timescale 1ns / 1ps
// kiss_cell: one slot of the insertion chain, holds a (key, index) pair.
// Depends on kiss_pkg.
module kiss_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kiss_pkg::cell_ctrl_t ctrl_i,
  input  kiss_pkg::key_t      new_key_i,
  input  kiss_pkg::idx_t      new_idx_i,
  input  kiss_pkg::cell_t     left_i,
  input  logic                left_lt_i,
  input  kiss_pkg::cell_t     right_i,
  output logic                lt_o,
  output kiss_pkg::cell_t     cell_o
);
  import kiss_pkg::*;

  cell_t cell_q, cell_d;

  // empty slots act as +infinity; equal keys do not displace
  assign lt_o   = !cell_q.valid || (new_key_i < cell_q.key);
  assign cell_o = cell_q;

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.shift_out) begin
      cell_d = right_i;
    end else if (ctrl_i.insert) begin
      if (left_lt_i) begin
        cell_d = left_i;
      end else if (lt_o) begin
        cell_d = '{valid: 1'b1, key: new_key_i, idx: new_idx_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

endmodule

### rtl/core/key_index_stable_sort.sv
`timescale 1ns / 1ps
// key_index_stable_sort: stable ascending sorter on a chain of insertion cells.
// Depends on kiss_pkg, kiss_if, kiss_cell.
//
//  channel  dir  payload                                  transaction
//  in_i     in   key, last_item                           one key loaded
//  out_o    out  sorted_key, origin_index, final_pair     one sorted pair
//
// Loading accepts one key per cycle; keys are inserted in place as they arrive.
// After last_item, pairs leave the head of the chain one per cycle while out_o.ready
// is high. in_i.ready is low while a set drains. Reset empties the chain at once.
// Keys beyond ENTRIES are dropped.
module key_index_stable_sort #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kiss_in_if.sink    in_i,
  kiss_out_if.source out_o
);
  import kiss_pkg::*;

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  state_e         state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  cell_ctrl_t     ctrl;
  cell_t          cells [ENTRIES];
  logic           lt    [ENTRIES];
  logic           in_acc, out_acc, room;

  assign in_i.ready = (state_q == StLoad);
  assign in_acc     = in_i.valid && in_i.ready;
  assign room       = (count_q < CntW'(ENTRIES));

  assign out_o.valid        = (state_q == StDrain) && cells[0].valid;
  assign out_o.sorted_key   = cells[0].key;
  assign out_o.origin_index = cells[0].idx;
  assign out_o.final_pair   = !cells[1].valid;
  assign out_acc            = out_o.valid && out_o.ready;

  assign ctrl.insert    = in_acc && room;
  assign ctrl.shift_out = out_acc;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    cell_t left_c, right_c;
    logic  left_lt;
    if (g == 0) begin : g_head
      assign left_c  = '0;
      assign left_lt = 1'b0;
    end else begin : g_mid
      assign left_c  = cells[g-1];
      assign left_lt = lt[g-1];
    end
    if (g == ENTRIES - 1) begin : g_tail
      assign right_c = '0;
    end else begin : g_body
      assign right_c = cells[g+1];
    end
    kiss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .new_key_i(in_i.key),
      .new_idx_i(IdxW'(count_q)),
      .left_i   (left_c),
      .left_lt_i(left_lt),
      .right_i  (right_c),
      .lt_o     (lt[g]),
      .cell_o   (cells[g])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (room) count_d = count_q + CntW'(1);
          if (in_i.last_item) state_d = StDrain;
        end
      end
      StDrain: begin
        if (out_acc && out_o.final_pair) begin
          state_d = StLoad;
          count_d = '0;
        end
      end
      default: begin
        state_d = StLoad;
        count_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("load and drain overlap");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ENTRIES))
    else $error("fill count beyond capacity");

  a_close_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.last_item) |=> out_o.valid)
    else $error("closed set produced no pair");

  a_drain_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_o.final_pair) |=> out_o.valid)
    else $error("set ended before final pair");

  a_drain_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !out_o.final_pair) |=> ($past(out_o.sorted_key) <= out_o.sorted_key))
    else $error("pairs out of order");

endmodule
